>>> rtl/core/cwi_pkg.sv
// Shared types and constants for the calibrated weight interpolator.
// Used by cwi_ctrl, cwi_dp and calibrated_weight_interpolator_unit.
`default_nettype none

package cwi_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Input commands.
  localparam logic CMD_POINT  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_UNIT     = 3'd0;
  localparam logic [2:0] REG_OVERLOAD = 3'd1;
  localparam logic [2:0] REG_FULL     = 3'd2;
  localparam logic [2:0] REG_HEAVY    = 3'd3;
  localparam logic [2:0] REG_EMPTY    = 3'd4;

  // Unit selection codes.
  localparam logic [1:0] UNIT_X10  = 2'd0;
  localparam logic [1:0] UNIT_X1   = 2'd1;
  localparam logic [1:0] UNIT_D10  = 2'd2;
  localparam logic [1:0] UNIT_D100 = 2'd3;

  // Load classes.
  localparam logic [2:0] CLS_EMPTY    = 3'd0;
  localparam logic [2:0] CLS_LIGHT    = 3'd1;
  localparam logic [2:0] CLS_HEAVY    = 3'd2;
  localparam logic [2:0] CLS_FULL     = 3'd3;
  localparam logic [2:0] CLS_OVERLOAD = 3'd4;

  // Serial arithmetic lengths: 33 x 33 bit multiply, 66 bit dividend.
  localparam int MUL_STEPS = 33;
  localparam int DIV_STEPS = 66;

  // Reciprocals for exact unsigned 32 bit division by 10 and by 100.
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP100   = 32'h51EB_851F;
  localparam logic [31:0] X10_LIMIT  = 32'd429496729;

  typedef struct packed {
    logic load_sample;
    logic wr_point;
    logic rd;
    logic chk;
    logic sel;
    logic mul;
    logic div;
    logic fin;
    logic scale;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic entry_end;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/cwi_ctrl.sv
// Sequencer for the calibrated weight interpolator.
// Depends on cwi_pkg; drives the command word of cwi_dp.
`default_nettype none

module cwi_ctrl #(
  parameter int MAX_POINTS = cwi_pkg::MAX_POINTS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_accept,
  input  wire                              in_command,
  input  cwi_pkg::status_t                 st,
  output cwi_pkg::cmd_t                    cmd,
  output logic [$clog2(MAX_POINTS)-1:0]    rd_addr,
  output logic                             busy
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = ($clog2(MAX_POINTS + 1) > 7) ? $clog2(MAX_POINTS + 1) : 7;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CK   = 4'd2;
  localparam logic [3:0] S_SEL  = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_SCL  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_command == cwi_pkg::CMD_SAMPLE) begin
            cmd.load_sample = 1'b1;
            cnt_nxt         = '0;
            state_nxt       = S_RD;
          end else begin
            cmd.wr_point = 1'b1;
          end
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CK;
      end
      S_CK: begin
        if (st.entry_end) begin
          state_nxt = S_SEL;
        end else begin
          cmd.chk = 1'b1;
          if (cnt_r == CNT_W'(MAX_POINTS - 1)) begin
            state_nxt = S_SEL;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_SEL: begin
        cmd.sel   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (cnt_r == CNT_W'(cwi_pkg::MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (cnt_r == CNT_W'(cwi_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_SCL;
      end
      S_SCL: begin
        cmd.scale = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign rd_addr = cnt_r[IDX_W-1:0];
  assign busy    = (state_r != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/cwi_dp.sv
// Datapath of the calibrated weight interpolator: table memory, scan
// registers, serial multiplier and divider, scaling and classification.
// Depends on cwi_pkg; sequenced by cwi_ctrl.
`default_nettype none

module cwi_dp #(
  parameter int MAX_POINTS = cwi_pkg::MAX_POINTS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  cwi_pkg::cmd_t                  cmd,
  input  wire [$clog2(MAX_POINTS)-1:0]   rd_addr,
  output cwi_pkg::status_t               st,
  input  wire                            cfg_we,
  input  wire [2:0]                      cfg_index,
  input  wire [31:0]                     cfg_wdata,
  input  wire [5:0]                      in_point_index,
  input  wire [31:0]                     in_point_reading,
  input  wire [31:0]                     in_point_weight,
  input  wire [15:0]                     in_sample,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [31:0]                    out_weight,
  output logic [2:0]                     out_load_class
);

  localparam int IDX_W = $clog2(MAX_POINTS);

  // Configuration registers.
  logic [1:0]  unit_r;
  logic [31:0] ovl_r, full_r, heavy_r, empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r  <= cwi_pkg::UNIT_X1;
      ovl_r   <= cwi_pkg::ALL_ONES;
      full_r  <= cwi_pkg::ALL_ONES;
      heavy_r <= cwi_pkg::ALL_ONES;
      empty_r <= cwi_pkg::ALL_ONES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cwi_pkg::REG_UNIT:     unit_r  <= cfg_wdata[1:0];
        cwi_pkg::REG_OVERLOAD: ovl_r   <= cfg_wdata;
        cwi_pkg::REG_FULL:     full_r  <= cfg_wdata;
        cwi_pkg::REG_HEAVY:    heavy_r <= cfg_wdata;
        cwi_pkg::REG_EMPTY:    empty_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Calibration table; an entry never written reads as the end marker.
  logic [63:0]           mem [MAX_POINTS];
  logic [MAX_POINTS-1:0] vld_r;
  logic [63:0]           rd_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      k_q;
  logic [8:0]            wr_ext;
  logic [IDX_W-1:0]      wr_addr;
  logic                  wr_ok;

  assign wr_ext  = 9'(in_point_index);
  assign wr_addr = wr_ext[IDX_W-1:0];
  assign wr_ok   = cmd.wr_point && (wr_ext < 9'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= {in_point_reading, in_point_weight};
    end
    if (cmd.rd) begin
      rd_q     <= mem[rd_addr];
      rd_vld_q <= vld_r[rd_addr];
      k_q      <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  logic [31:0] ent_r, ent_w;
  assign ent_r = rd_vld_q ? rd_q[63:32] : cwi_pkg::ALL_ONES;
  assign ent_w = rd_vld_q ? rd_q[31:0]  : cwi_pkg::ALL_ONES;
  assign st.entry_end = (ent_r == cwi_pkg::ALL_ONES) || (ent_w == cwi_pkg::ALL_ONES);

  // Scan registers.
  logic [31:0] s_r;
  logic [1:0]  n_r;
  logic        hit_r, hit0_r;
  logic [63:0] e0_r, e1_r, prev_r, last_r, hlo_r, hhi_r;

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      s_r   <= 32'(in_sample);
      n_r   <= '0;
      hit_r <= 1'b0;
    end else if (cmd.chk) begin
      if (n_r != 2'd2) n_r <= n_r + 1'b1;
      prev_r <= last_r;
      last_r <= {ent_r, ent_w};
      if (k_q == '0)           e0_r <= {ent_r, ent_w};
      if (k_q == IDX_W'(1))    e1_r <= {ent_r, ent_w};
      if (!hit_r && (s_r <= ent_r)) begin
        hit_r  <= 1'b1;
        hit0_r <= (k_q == '0);
        hlo_r  <= last_r;
        hhi_r  <= {ent_r, ent_w};
      end
    end
  end

  // Pair selection.
  logic [63:0]        lo, hi;
  logic               dir_neg;
  logic signed [32:0] span, dr, dw;
  logic               above;

  always_comb begin
    above = (s_r >= last_r[63:32]);
    if (above) begin
      lo = prev_r; hi = last_r; dir_neg = 1'b0;
      span = $signed({1'b0, s_r}) - $signed({1'b0, prev_r[63:32]});
    end else if (hit0_r) begin
      lo = e0_r; hi = e1_r; dir_neg = 1'b1;
      span = $signed({1'b0, e0_r[63:32]}) - $signed({1'b0, s_r});
    end else begin
      lo = hlo_r; hi = hhi_r; dir_neg = 1'b0;
      span = $signed({1'b0, s_r}) - $signed({1'b0, hlo_r[63:32]});
    end
    dr = $signed({1'b0, hi[63:32]}) - $signed({1'b0, lo[63:32]});
    dw = $signed({1'b0, hi[31:0]})  - $signed({1'b0, lo[31:0]});
  end

  logic [31:0] base_r, direct_val_r;
  logic        direct_r, neg_r, dneg_r;
  logic [32:0] d_r, mb_r;
  logic [65:0] ma_r, p_r;
  logic [32:0] rem_r;
  logic [33:0] dv_t;

  assign dv_t = {rem_r, p_r[65]};

  always_ff @(posedge clk) begin
    if (cmd.sel) begin
      base_r       <= lo[31:0];
      direct_r     <= (n_r != 2'd2) || (dr == '0);
      direct_val_r <= (n_r != 2'd2) ? '0 : lo[31:0];
      neg_r        <= span[32] ^ dw[32] ^ dr[32];
      dneg_r       <= dir_neg;
      d_r          <= dr[32] ? 33'(-dr) : 33'(dr);
      ma_r         <= 66'(span[32] ? 33'(-span) : 33'(span));
      mb_r         <= dw[32] ? 33'(-dw) : 33'(dw);
      p_r          <= '0;
      rem_r        <= '0;
    end else if (cmd.mul) begin
      if (mb_r[0]) p_r <= p_r + ma_r;
      ma_r <= {ma_r[64:0], 1'b0};
      mb_r <= {1'b0, mb_r[32:1]};
    end else if (cmd.div) begin
      if (dv_t >= {1'b0, d_r}) begin
        rem_r <= 33'(dv_t - {1'b0, d_r});
        p_r   <= {p_r[64:0], 1'b1};
      end else begin
        rem_r <= dv_t[32:0];
        p_r   <= {p_r[64:0], 1'b0};
      end
    end
  end

  // Rounding, cap, signed add and saturation.
  logic        rnd, sgn;
  logic [66:0] q1;
  logic [33:0] qc;
  logic [35:0] v;
  logic [31:0] sat;
  logic [31:0] raw_r;

  always_comb begin
    rnd = neg_r ? ({rem_r, 1'b0} > {1'b0, d_r}) : ({rem_r, 1'b0} >= {1'b0, d_r});
    q1  = {1'b0, p_r} + 67'(rnd);
    qc  = (q1 > (67'(1) << 33)) ? (34'(1) << 33) : q1[33:0];
    sgn = neg_r ^ dneg_r;
    v   = sgn ? ({4'b0, base_r} - {2'b0, qc}) : ({4'b0, base_r} + {2'b0, qc});
    if (v[35])               sat = '0;
    else if (v[34:32] != '0) sat = cwi_pkg::ALL_ONES;
    else                     sat = v[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) raw_r <= direct_r ? direct_val_r : sat;
  end

  // Unit scaling.
  logic [63:0] prod;
  logic [31:0] scaled, scaled_r;

  always_comb begin
    prod = 64'(raw_r) * 64'((unit_r == cwi_pkg::UNIT_D100) ? cwi_pkg::RECIP100
                                                           : cwi_pkg::RECIP10);
    case (unit_r)
      cwi_pkg::UNIT_X10:
        scaled = (raw_r > cwi_pkg::X10_LIMIT) ? cwi_pkg::ALL_ONES
                                              : 32'({raw_r, 3'b0} + {raw_r, 1'b0});
      cwi_pkg::UNIT_D10:  scaled = 32'(prod[63:35]);
      cwi_pkg::UNIT_D100: scaled = 32'(prod[63:37]);
      default:            scaled = raw_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) scaled_r <= scaled;
  end

  // Classification and output register.
  logic [2:0] cls;
  always_comb begin
    if (scaled_r > ovl_r)        cls = cwi_pkg::CLS_OVERLOAD;
    else if (scaled_r > full_r)  cls = cwi_pkg::CLS_FULL;
    else if (scaled_r > heavy_r) cls = cwi_pkg::CLS_HEAVY;
    else if (scaled_r > empty_r) cls = cwi_pkg::CLS_LIGHT;
    else                         cls = cwi_pkg::CLS_EMPTY;
  end

  logic out_valid_r;
  assign st.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_weight     <= scaled_r;
      out_load_class <= cls;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/core/calibrated_weight_interpolator_unit.sv
// Top level of the calibrated weight interpolator.
// Depends on cwi_pkg, cwi_ctrl and cwi_dp.
`default_nettype none

// A point word (command 0) writes one calibration point and yields no
// result. A sample word (command 1) is converted to a weight and yields one
// result word. A conversion scans the table with one memory read and one
// check per entry, up to MAX_POINTS entries, then selects the pair, runs the
// serial multiplier and the serial restoring divider, and finishes with
// rounding, unit scaling and classification. The block holds in_stall high
// while a conversion runs. A finished result waits in the output register
// while the next word is already accepted. Table entries reset to the end
// marker through per-entry valid flags, so no clearing pass is needed after
// reset.

module calibrated_weight_interpolator_unit #(
  parameter int MAX_POINTS = cwi_pkg::MAX_POINTS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_command,
  input  wire  [5:0]  in_point_index,
  input  wire  [31:0] in_point_reading,
  input  wire  [31:0] in_point_weight,
  input  wire  [15:0] in_sample,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_weight,
  output logic [2:0]  out_load_class,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_wdata
);

  cwi_pkg::cmd_t                 cmd;
  cwi_pkg::status_t              st;
  logic [$clog2(MAX_POINTS)-1:0] rd_addr;
  logic                          busy;
  logic                          in_accept;

  // Words are taken only while no conversion is in progress.
  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;

  cwi_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_command (in_command),
    .st         (st),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .busy       (busy)
  );

  cwi_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .rd_addr          (rd_addr),
    .st               (st),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_point_index   (in_point_index),
    .in_point_reading (in_point_reading),
    .in_point_weight  (in_point_weight),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_weight       (out_weight),
    .out_load_class   (out_load_class)
  );

  // A sample word starts a conversion on the next cycle.
  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_command == cwi_pkg::CMD_SAMPLE) |=> in_stall)
    else $error("conversion did not start");

  // A point word never makes the block busy.
  a_point_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_command == cwi_pkg::CMD_POINT) |=> !in_stall)
    else $error("point write made block busy");

  // A new result only appears at the end of a conversion.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without conversion");

endmodule

`default_nettype wire
